FILE: sv/gpm_pkg.sv
package gpm_pkg;

  // Stick axes are centred here; a deviation above the limit makes a stick active.
  localparam logic [7:0] AxisCentre = 8'd128;
  localparam logic [7:0] ActiveLimit = 8'd64;

  // Bits of the first button byte (active low).
  localparam int unsigned BtnSelect = 0;

  // Bits of the second button byte (active low).
  localparam int unsigned BtnL2 = 0;
  localparam int unsigned BtnR2 = 1;
  localparam int unsigned BtnL1 = 2;
  localparam int unsigned BtnR1 = 3;
  localparam int unsigned BtnTriangle = 4;
  localparam int unsigned BtnCircle = 5;
  localparam int unsigned BtnSquare = 7;

  // Layout modes. Code 3 is never written and is handled like ambidextrous.
  typedef enum logic [1:0] {
    LAYOUT_AMBI  = 2'd0,
    LAYOUT_LEFT  = 2'd1,
    LAYOUT_RIGHT = 2'd2
  } layout_mode_t;

  // Stick choice for each port, handed from the layout control to the datapath.
  typedef struct packed {
    layout_mode_t mode;
    logic         a_left;
    logic         b_left;
  } stick_sel_t;

  // Distance of an axis from centre, 0..128.
  function automatic logic [7:0] axis_deviation(input logic [7:0] v);
    logic [7:0] dev;
    if (v >= AxisCentre) begin
      dev = v - AxisCentre;
    end else begin
      dev = AxisCentre - v;
    end
    return dev;
  endfunction

endpackage

FILE: sv/gpm_layout_ctrl.sv
module gpm_layout_ctrl import gpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] button_byte_low,
  input  logic [7:0] button_byte_high,
  input  logic [7:0] right_x,
  input  logic [7:0] right_y,
  input  logic [7:0] left_x,
  input  logic [7:0] left_y,
  output stick_sel_t sel
);

  layout_mode_t mode, mode_next;
  logic         active_stick, active_stick_next;
  logic [7:0]   dev_right, dev_left;

  // Larger deviation of each stick.
  always_comb begin
    dev_right = (axis_deviation(right_x) > axis_deviation(right_y)) ?
                axis_deviation(right_x) : axis_deviation(right_y);
    dev_left  = (axis_deviation(left_x) > axis_deviation(left_y)) ?
                axis_deviation(left_x) : axis_deviation(left_y);
  end

  // Active stick follows deflection only in ambidextrous mode; right stick wins.
  always_comb begin
    active_stick_next = active_stick;
    if (mode != LAYOUT_LEFT && mode != LAYOUT_RIGHT) begin
      priority if (dev_right > ActiveLimit) begin
        active_stick_next = 1'b0;
      end else if (dev_left > ActiveLimit) begin
        active_stick_next = 1'b1;
      end else begin
        active_stick_next = active_stick;
      end
    end
  end

  // Select plus a mode button picks the layout for the following frame.
  always_comb begin
    mode_next = mode;
    if (!button_byte_low[BtnSelect]) begin
      priority if (!button_byte_high[BtnTriangle]) begin
        mode_next = LAYOUT_AMBI;
      end else if (!button_byte_high[BtnSquare]) begin
        mode_next = LAYOUT_LEFT;
      end else if (!button_byte_high[BtnCircle]) begin
        mode_next = LAYOUT_RIGHT;
      end else begin
        mode_next = mode;
      end
    end
  end

  // Stick routing for the frame now being processed.
  always_comb begin
    sel.mode = mode;
    unique case (mode)
      LAYOUT_LEFT: begin
        sel.a_left = 1'b1;
        sel.b_left = 1'b0;
      end
      LAYOUT_RIGHT: begin
        sel.a_left = 1'b0;
        sel.b_left = 1'b1;
      end
      default: begin
        sel.a_left = active_stick_next;
        sel.b_left = active_stick_next;
      end
    endcase
  end

  // State moves only when a frame passes into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= LAYOUT_AMBI;
      active_stick <= 1'b0;
    end else if (advance) begin
      mode         <= mode_next;
      active_stick <= active_stick_next;
    end
  end

endmodule

FILE: sv/gpm_pot_scale.sv
module gpm_pot_scale import gpm_pkg::*; (
  input  logic [7:0] axis_x,
  input  logic [7:0] axis_y,
  output logic [7:0] pot_x,
  output logic [7:0] pot_y
);

  // floor(m*17/20) and floor(m*18/20) for m <= 128 as one multiply and a shift:
  // the reciprocal error stays below the smallest fractional gap of the quotient.
  localparam int unsigned RecipShift = 16;
  localparam logic [15:0] ScaleX = 16'd55709;
  localparam logic [15:0] ScaleY = 16'd58986;
  localparam logic [7:0] OffsetX = 8'd124;

  logic [7:0]  mag_x, mag_y;
  logic [23:0] prod_x, prod_y;
  logic [7:0]  quo_x, quo_y;

  // Magnitude times the scale; the sign is put back after the truncation.
  always_comb begin
    mag_x  = axis_deviation(axis_x);
    mag_y  = axis_deviation(axis_y);
    prod_x = {16'd0, mag_x} * {8'd0, ScaleX};
    prod_y = {16'd0, mag_y} * {8'd0, ScaleY};
    quo_x  = prod_x[RecipShift +: 8];
    quo_y  = prod_y[RecipShift +: 8];
  end

  // Truncation toward zero: subtract the magnitude quotient below centre.
  always_comb begin
    pot_x = axis_x[7] ? (OffsetX + quo_x) : (OffsetX - quo_x);
    pot_y = axis_y[7] ? (AxisCentre + quo_y) : (AxisCentre - quo_y);
  end

endmodule

FILE: sv/gamepad_to_paddle_mapper.sv
// Maps one polled gamepad frame per transaction to two paddle ports: four pot
// values and two trigger levels. A frame is taken every clock cycle while the
// result side keeps up. An accepted frame passes from the input register
// through the scaling logic into the result register, which drives the
// outputs. The layout mode and active stick registers are updated as each
// frame moves into the result register. Select together with triangle,
// square or circle changes the layout from the following frame on. Reset puts
// the block in ambidextrous mode with the right stick active.
module gamepad_to_paddle_mapper import gpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] button_byte_low,
  input  logic [7:0] button_byte_high,
  input  logic [7:0] right_x,
  input  logic [7:0] right_y,
  input  logic [7:0] left_x,
  input  logic [7:0] left_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pot_a_x,
  output logic [7:0] pot_a_y,
  output logic [7:0] pot_b_x,
  output logic [7:0] pot_b_y,
  output logic       trigger_a,
  output logic       trigger_b
);

  logic       in_full;
  logic [7:0] btn_low, btn_high, rx, ry, lx, ly;
  logic       advance;
  stick_sel_t sel;
  logic [7:0] a_x, a_y, b_x, b_y;
  logic [7:0] pa_x, pa_y, pb_x, pb_y;

  // A frame moves on when the result register is empty or being emptied.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      btn_low  <= button_byte_low;
      btn_high <= button_byte_high;
      rx       <= right_x;
      ry       <= right_y;
      lx       <= left_x;
      ly       <= left_y;
    end
  end

  // Layout mode and active stick.
  gpm_layout_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .button_byte_low  (btn_low),
    .button_byte_high (btn_high),
    .right_x          (rx),
    .right_y          (ry),
    .left_x           (lx),
    .left_y           (ly),
    .sel              (sel)
  );

  // Stick routing to the two ports.
  always_comb begin
    a_x = sel.a_left ? lx : rx;
    a_y = sel.a_left ? ly : ry;
    b_x = sel.b_left ? lx : rx;
    b_y = sel.b_left ? ly : ry;
  end

  gpm_pot_scale u_scale_a (
    .axis_x (a_x),
    .axis_y (a_y),
    .pot_x  (pa_x),
    .pot_y  (pa_y)
  );

  gpm_pot_scale u_scale_b (
    .axis_x (b_x),
    .axis_y (b_y),
    .pot_x  (pb_x),
    .pot_y  (pb_y)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pot_a_x   <= pa_x;
      pot_a_y   <= pa_y;
      pot_b_x   <= pb_x;
      pot_b_y   <= pb_y;
      trigger_a <= btn_high[BtnL1] && btn_high[BtnR1];
      trigger_b <= btn_high[BtnL2] && btn_high[BtnR2];
    end
  end

  // In ambidextrous mode both ports follow the same stick.
  a_ambi_same : assert property (@(posedge clk) disable iff (rst)
    advance && (sel.mode != LAYOUT_LEFT) && (sel.mode != LAYOUT_RIGHT)
    |=> (pot_a_x == pot_b_x) && (pot_a_y == pot_b_y))
    else $error("ambidextrous ports differ");

  // A held frame is never dropped from the input register.
  a_in_hold : assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full)
    else $error("input frame lost");

  // The input side stalls only behind a full, blocked result register.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && out_valid && out_stall)
    else $error("stall without a blocked result");

  // Trigger A follows both shoulder bits of the frame that moved on.
  a_trigger_a : assert property (@(posedge clk) disable iff (rst)
    advance |=> trigger_a == ($past(btn_high[BtnL1]) && $past(btn_high[BtnR1])))
    else $error("trigger A mismatch");

endmodule
